// ----- src/blm_pkg.sv -----
package blm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 20;
    localparam int SUM_W      = 41;
    localparam int SQ_W       = 56;
    localparam int PEAK_W     = 16;
    localparam int RMS_W      = 18;
    localparam int LEN_W      = 22;
    localparam int SLOT_W     = 5;
    localparam int MAX_VOICES = 16;
    localparam logic [LEN_W-1:0] LEN_RESET = 22'd24000;
    localparam logic [LEN_W-1:0] LEN_MAX   = 22'd2400000;
    localparam logic [LEN_W-1:0] LEN_MIN   = 22'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_a;
        logic                       valid_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic                       valid_b;
        logic                       frame_end;
    } in_word_t;

    typedef struct packed {
        logic signed [FRAME_W-1:0] frame_sum_a;
        logic signed [FRAME_W-1:0] frame_sum_b;
        logic                      stats_valid;
        logic signed [FRAME_W-1:0] dc_a;
        logic signed [FRAME_W-1:0] dc_b;
        logic [RMS_W-1:0]          rms_a;
        logic [RMS_W-1:0]          rms_b;
        logic [PEAK_W-1:0]         peak_a;
        logic [PEAK_W-1:0]         peak_b;
    } out_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]           sq;
        logic [PEAK_W-1:0]         peak;
        logic signed [FRAME_W-1:0] frame;
    } lane_acc_t;

    typedef struct packed {
        logic signed [FRAME_W-1:0] dc;
        logic [RMS_W-1:0]          rms;
    } lane_stat_t;

    typedef struct packed {
        logic add;
        logic clear_frame;
        logic clear_block;
    } lane_ctl_t;

endpackage

// ----- src/blm_lane.sv -----
module blm_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  blm_pkg::lane_ctl_t                  ctl,
    input  logic signed [blm_pkg::SAMPLE_W-1:0] sample,
    output blm_pkg::lane_acc_t                  acc,
    output logic signed [blm_pkg::FRAME_W-1:0]  frame_sum
);
    import blm_pkg::*;

    lane_acc_t acc_reg, acc_next;
    logic [SAMPLE_W:0]       mag;
    logic [2*SAMPLE_W+1:0]   sqv;
    logic signed [SUM_W:0]   sum_w;
    logic [SQ_W:0]           sq_w;
    logic signed [FRAME_W:0] fr_w;
    logic signed [FRAME_W-1:0] fr_sat;

    assign mag = sample[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({sample[SAMPLE_W-1], sample}))
                                   : {1'b0, sample};
    assign sqv = (2*SAMPLE_W+2)'(mag) * (2*SAMPLE_W+2)'(mag);

    always_comb begin
        acc_next = acc_reg;
        fr_sat = acc_reg.frame;
        sum_w = (SUM_W+1)'(acc_reg.sum) + (SUM_W+1)'(sample);
        sq_w  = {1'b0, acc_reg.sq} + (SQ_W+1)'(sqv);
        fr_w  = (FRAME_W+1)'(acc_reg.frame) + (FRAME_W+1)'(sample);
        if (ctl.add) begin
            if (sum_w[SUM_W] != sum_w[SUM_W-1])
                acc_next.sum = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
            else
                acc_next.sum = sum_w[SUM_W-1:0];
            acc_next.sq = sq_w[SQ_W] ? '1 : sq_w[SQ_W-1:0];
            if (mag[SAMPLE_W])
                acc_next.peak = '1;
            else if (mag[PEAK_W-1:0] > acc_reg.peak)
                acc_next.peak = mag[PEAK_W-1:0];
            if (fr_w[FRAME_W] != fr_w[FRAME_W-1])
                fr_sat = fr_w[FRAME_W] ? {1'b1, {(FRAME_W-1){1'b0}}}
                                       : {1'b0, {(FRAME_W-1){1'b1}}};
            else
                fr_sat = fr_w[FRAME_W-1:0];
        end
        acc_next.frame = ctl.clear_frame ? '0 : fr_sat;
        if (ctl.clear_block) begin
            acc_next.sum  = '0;
            acc_next.sq   = '0;
            acc_next.peak = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) acc_reg <= '0;
        else          acc_reg <= acc_next;
    end

    assign acc       = acc_reg;
    assign frame_sum = fr_sat;
endmodule

// ----- src/blm_stat.sv -----
module blm_stat (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [blm_pkg::SUM_W-1:0]   sum,
    input  logic [blm_pkg::SQ_W-1:0]           sq,
    input  logic [blm_pkg::LEN_W-1:0]          count,
    output logic                               done,
    output blm_pkg::lane_stat_t                stat
);
    import blm_pkg::*;

    localparam int QW = SQ_W;
    localparam int CW = $clog2(QW + 1);
    localparam int RW = SQ_W / 2;
    localparam int RCW = $clog2(RW + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_DONE = 4'b1000
    } st_t;

    st_t st_reg, st_next;
    logic [QW-1:0]    sq_q_reg;
    logic [LEN_W:0]   sq_r_reg;
    logic [SUM_W-1:0] sm_q_reg;
    logic [LEN_W:0]   sm_r_reg;
    logic             neg_reg;
    logic [LEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic [QW-1:0]    rad_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW-1:0]    root_reg;
    logic [RCW-1:0]   rcnt_reg;
    lane_stat_t       stat_val;

    logic [LEN_W:0]   sq_sh, sm_sh;
    logic [RW+1:0]    rem_sh, trial;
    logic signed [SUM_W-1:0] dcs;

    assign sq_sh  = {sq_r_reg[LEN_W-1:0], sq_q_reg[QW-1]};
    assign sm_sh  = {sm_r_reg[LEN_W-1:0], sm_q_reg[SUM_W-1]};
    assign rem_sh = {rem_reg[RW-1:0], rad_reg[QW-1:QW-2]};
    assign trial  = {root_reg, 2'b01};
    assign dcs    = neg_reg ? -$signed(sm_q_reg) : $signed(sm_q_reg);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (start) st_next = ST_DIV;
            ST_DIV:  if (32'(cnt_reg) == QW - 1) st_next = ST_SQRT;
            ST_SQRT: if (32'(rcnt_reg) == RW - 1) st_next = ST_DONE;
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= ST_IDLE;
        else          st_reg <= st_next;
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            ST_IDLE: begin
                sq_q_reg <= sq;
                sq_r_reg <= '0;
                neg_reg  <= sum[SUM_W-1];
                sm_q_reg <= sum[SUM_W-1] ? SUM_W'(-sum) : sum;
                sm_r_reg <= '0;
                den_reg  <= count;
                cnt_reg  <= '0;
                rcnt_reg <= '0;
            end
            ST_DIV: begin
                if (sq_sh >= {1'b0, den_reg}) begin
                    sq_r_reg <= sq_sh - {1'b0, den_reg};
                    sq_q_reg <= {sq_q_reg[QW-2:0], 1'b1};
                end else begin
                    sq_r_reg <= sq_sh;
                    sq_q_reg <= {sq_q_reg[QW-2:0], 1'b0};
                end
                if (32'(cnt_reg) < SUM_W) begin
                    if (sm_sh >= {1'b0, den_reg}) begin
                        sm_r_reg <= sm_sh - {1'b0, den_reg};
                        sm_q_reg <= {sm_q_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        sm_r_reg <= sm_sh;
                        sm_q_reg <= {sm_q_reg[SUM_W-2:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (32'(cnt_reg) == QW - 1) begin
                    rad_reg  <= (sq_sh >= {1'b0, den_reg}) ? {sq_q_reg[QW-2:0], 1'b1}
                                                          : {sq_q_reg[QW-2:0], 1'b0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            ST_SQRT: begin
                rad_reg <= {rad_reg[QW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                rcnt_reg <= rcnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (dcs > $signed(SUM_W'(524287)))
            stat_val.dc = {1'b0, {(FRAME_W-1){1'b1}}};
        else if (dcs < -$signed(SUM_W'(524288)))
            stat_val.dc = {1'b1, {(FRAME_W-1){1'b0}}};
        else
            stat_val.dc = dcs[FRAME_W-1:0];
        stat_val.rms = (|root_reg[RW-1:RMS_W]) ? '1 : root_reg[RMS_W-1:0];
    end

    assign done = (st_reg == ST_DONE);
    assign stat = stat_val;
endmodule

// ----- src/block_level_meter.sv -----
// Two-port block level meter. Each input word is one voice slot with a sample and
// a present flag for ports A and B; a word with frame_end set yields one output word
// with both frame sums. When the frame count reaches block_length (clamped to
// 2..MAX_BLOCK_FRAMES) the output also carries DC, RMS and peak per port, then
// the block clears. Ordinary words are taken back to back unless the output is
// stalled. A block-closing word holds off the input until its stats are posted:
// a registered start, a shared-nothing divider per port of 56 restoring steps,
// a 28-step square root, both ports in parallel, then the registered output word.
module block_level_meter #(
    parameter int MAX_BLOCK_FRAMES = 2400000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [21:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  blm_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output blm_pkg::out_word_t   m_data
);
    import blm_pkg::*;

    localparam logic [LEN_W-1:0] LMAX = LEN_W'(MAX_BLOCK_FRAMES);

    logic [LEN_W-1:0]  len_reg, len_sat;
    logic [LEN_W-1:0]  frames_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              busy_reg;
    logic              stats_pend_reg;
    out_word_t         out_reg;
    logic              out_valid_reg;
    logic [LEN_W-1:0]  fcount;
    lane_ctl_t ctl_a, ctl_b;
    lane_acc_t acc_a, acc_b;
    lane_stat_t st_a, st_b;
    logic signed [FRAME_W-1:0] frame_a, frame_b;
    logic done_a, done_b, acc, in_slot, close, blk;

    assign len_sat = (len_reg < LEN_MIN) ? LEN_MIN : (len_reg > LMAX) ? LMAX : len_reg;
    assign s_ready = !busy_reg && !(out_valid_reg && !m_ready);
    assign acc     = s_valid && s_ready;
    assign in_slot = 32'(slot_reg) < MAX_VOICES;
    assign fcount  = frames_reg + 1'b1;
    assign close   = acc && s_data.frame_end;
    assign blk     = close && (fcount >= len_sat);

    assign ctl_a.add = acc && in_slot && s_data.valid_a;
    assign ctl_b.add = acc && in_slot && s_data.valid_b;
    assign ctl_a.clear_frame = close;
    assign ctl_b.clear_frame = close;
    assign ctl_a.clear_block = done_a;
    assign ctl_b.clear_block = done_a;

    blm_lane u_lane_a (.aclk, .aresetn, .ctl(ctl_a), .sample(s_data.sample_a), .acc(acc_a),
                       .frame_sum(frame_a));
    blm_lane u_lane_b (.aclk, .aresetn, .ctl(ctl_b), .sample(s_data.sample_b), .acc(acc_b),
                       .frame_sum(frame_b));

    blm_stat u_stat_a (.aclk, .aresetn, .start(stats_pend_reg), .sum(acc_a.sum),
                       .sq(acc_a.sq), .count(frames_reg), .done(done_a), .stat(st_a));
    blm_stat u_stat_b (.aclk, .aresetn, .start(stats_pend_reg), .sum(acc_b.sum),
                       .sq(acc_b.sq), .count(frames_reg), .done(done_b), .stat(st_b));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= LEN_RESET;
            frames_reg     <= '0;
            slot_reg       <= '0;
            busy_reg       <= 1'b0;
            stats_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) len_reg <= cfg_wdata;
            stats_pend_reg <= 1'b0;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (acc) begin
                if (in_slot) slot_reg <= slot_reg + 1'b1;
                if (close) begin
                    slot_reg   <= '0;
                    frames_reg <= fcount;
                    out_reg.frame_sum_a <= frame_a;
                    out_reg.frame_sum_b <= frame_b;
                    out_reg.stats_valid <= 1'b0;
                    out_reg.dc_a   <= '0;
                    out_reg.dc_b   <= '0;
                    out_reg.rms_a  <= '0;
                    out_reg.rms_b  <= '0;
                    out_reg.peak_a <= '0;
                    out_reg.peak_b <= '0;
                    if (blk) begin
                        busy_reg       <= 1'b1;
                        stats_pend_reg <= 1'b1;
                    end else begin
                        out_valid_reg <= 1'b1;
                    end
                end
            end
            if (done_a) begin
                out_reg.stats_valid <= 1'b1;
                out_reg.dc_a   <= st_a.dc;
                out_reg.dc_b   <= st_b.dc;
                out_reg.rms_a  <= st_a.rms;
                out_reg.rms_b  <= st_b.rms;
                out_reg.peak_a <= acc_a.peak;
                out_reg.peak_b <= acc_b.peak;
                out_valid_reg  <= done_b;
                frames_reg     <= '0;
                busy_reg       <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule
